// File: rtl/fsta_pkg.sv
`default_nettype none
package fsta_pkg;

  // field widths
  localparam int FRAME_W  = 32;
  localparam int STEP_W   = 28;
  localparam int CAP_W    = 8;
  localparam int TICK_W   = 48;
  localparam int DROP_W   = 48;
  localparam int INV_W    = 32;
  localparam int BLEND_W  = 16;

  // fraction bits of the blend quotient, 8 to 16
  localparam int FRAC_BITS = 16;

  // divider sizing: remainder plus frame time needs one extra bit
  localparam int SUM_W  = FRAME_W + 1;
  localparam int CAPSTEP_W = CAP_W + STEP_W;
  localparam int CNT_W  = $clog2(SUM_W + 1);

  // request queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = STEP_W;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_STEPS   = 2'd1;
  localparam logic [STEP_W-1:0]    STEP_RESET      = 28'd16666667;
  localparam logic [CAP_W-1:0]     CAP_RESET       = 8'd8;

  typedef struct packed {
    logic [FRAME_W-1:0] frame_time;
    logic               frame_invalid;
  } fsta_item_t;

  typedef struct packed {
    logic [STEP_W-1:0] step_length;
    logic [CAP_W-1:0]  max_steps;
  } fsta_cfg_t;

endpackage
`default_nettype wire

// File: rtl/fsta_front.sv
`default_nettype none
module fsta_front (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [31:0]          in_frame_time,
  input  wire logic                 in_frame_invalid,
  output logic                      q_valid,
  output fsta_pkg::fsta_item_t      q_item,
  input  wire logic                 q_pop
);

  fsta_pkg::fsta_item_t             mem_r [fsta_pkg::QDEPTH];
  logic [fsta_pkg::QPTR_W-1:0]      wr_ptr_r;
  logic [fsta_pkg::QPTR_W-1:0]      rd_ptr_r;
  logic [fsta_pkg::QCNT_W-1:0]      count_r;
  logic [fsta_pkg::QCNT_W-1:0]      count_nxt;
  fsta_pkg::fsta_item_t             item_in;
  logic                             push;
  logic                             pop;

  // classify: an invalid frame carries no time
  always_comb begin
    item_in.frame_invalid = in_frame_invalid;
    item_in.frame_time    = in_frame_invalid ? '0 : in_frame_time;
  end

  assign in_stall = (count_r == fsta_pkg::QCNT_W'(fsta_pkg::QDEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count_r != '0);
  assign pop      = q_pop && q_valid;
  assign q_item   = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= item_in;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= fsta_pkg::QPTR_W'((32'(wr_ptr_r) + 1) % fsta_pkg::QDEPTH);
      end
      if (pop) begin
        rd_ptr_r <= fsta_pkg::QPTR_W'((32'(rd_ptr_r) + 1) % fsta_pkg::QDEPTH);
      end
      count_r <= count_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/fsta_back.sv
`default_nettype none
module fsta_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire fsta_pkg::fsta_cfg_t  cfg,
  input  wire logic                 q_valid,
  input  wire fsta_pkg::fsta_item_t q_item,
  output logic                      q_pop,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [7:0]                out_steps_run,
  output logic [47:0]               out_total_ticks,
  output logic [15:0]               out_blend_fraction,
  output logic [47:0]               out_dropped_total,
  output logic [31:0]               out_invalid_count
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_POST,
    ST_FRAC,
    ST_FIN
  } state_t;

  state_t                               state_r;
  logic [fsta_pkg::STEP_W-1:0]          part_r;
  logic [fsta_pkg::SUM_W-1:0]           dvd_r;
  logic [fsta_pkg::SUM_W-1:0]           quo_r;
  logic [fsta_pkg::SUM_W-1:0]           sum_r;
  logic [fsta_pkg::CNT_W-1:0]           cnt_r;
  logic [fsta_pkg::CAPSTEP_W-1:0]       capstep_r;
  logic [fsta_pkg::CAP_W-1:0]           steps_r;
  logic                                 sat_r;
  logic [fsta_pkg::STEP_W-1:0]          remainder_r;
  logic [fsta_pkg::TICK_W-1:0]          tick_r;
  logic [fsta_pkg::DROP_W-1:0]          drop_r;
  logic [fsta_pkg::INV_W-1:0]           invc_r;
  logic                                 out_valid_r;
  logic [fsta_pkg::CAP_W-1:0]           out_steps_r;
  logic [fsta_pkg::TICK_W-1:0]          out_ticks_r;
  logic [fsta_pkg::BLEND_W-1:0]         out_blend_r;
  logic [fsta_pkg::DROP_W-1:0]          out_drop_r;
  logic [fsta_pkg::INV_W-1:0]           out_invc_r;

  logic [fsta_pkg::STEP_W-1:0]          step_eff;
  logic [fsta_pkg::STEP_W:0]            trial;
  logic                                 trial_ge;
  logic [fsta_pkg::STEP_W-1:0]          part_nxt;
  logic                                 over_cap;
  logic [fsta_pkg::SUM_W-1:0]           lost;
  logic [fsta_pkg::DROP_W:0]            drop_sum;
  logic [fsta_pkg::DROP_W-1:0]          drop_nxt;
  logic [fsta_pkg::CAP_W-1:0]           steps_nxt;
  logic                                 out_free;

  // a step length of zero counts as one
  assign step_eff = (cfg.step_length == '0) ? fsta_pkg::STEP_W'(1) : cfg.step_length;

  // one restoring division step: shift in the next dividend bit, try subtract
  assign trial    = {part_r, dvd_r[fsta_pkg::SUM_W-1]};
  assign trial_ge = (trial >= {1'b0, step_eff});
  assign part_nxt = trial_ge ? fsta_pkg::STEP_W'(trial - {1'b0, step_eff})
                             : trial[fsta_pkg::STEP_W-1:0];

  // cap check and dropped time: whole*step - cap*step = sum - rem - cap*step
  assign over_cap  = (quo_r > fsta_pkg::SUM_W'(cfg.max_steps));
  assign lost      = sum_r - fsta_pkg::SUM_W'(part_r) - fsta_pkg::SUM_W'(capstep_r);
  assign drop_sum  = {1'b0, drop_r} + (fsta_pkg::DROP_W + 1)'(lost);
  assign drop_nxt  = drop_sum[fsta_pkg::DROP_W] ? '1 : drop_sum[fsta_pkg::DROP_W-1:0];
  assign steps_nxt = over_cap ? cfg.max_steps : quo_r[fsta_pkg::CAP_W-1:0];

  assign out_free = !out_valid_r || !out_stall;
  assign q_pop    = (state_r == ST_IDLE) && q_valid;

  // sequencer, running state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      remainder_r <= '0;
      tick_r      <= '0;
      drop_r      <= '0;
      invc_r      <= '0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      sat_r       <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && (state_r != ST_FIN)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          capstep_r <= fsta_pkg::CAPSTEP_W'(cfg.max_steps) * fsta_pkg::CAPSTEP_W'(step_eff);
          if (q_valid) begin
            if (q_item.frame_invalid) begin
              invc_r  <= invc_r + 1'b1;
              steps_r <= '0;
              part_r  <= remainder_r;
              dvd_r   <= '0;
              cnt_r   <= fsta_pkg::CNT_W'(fsta_pkg::FRAC_BITS);
              sat_r   <= (remainder_r >= step_eff);
              state_r <= (remainder_r >= step_eff) ? ST_FIN : ST_FRAC;
            end else begin
              sum_r   <= fsta_pkg::SUM_W'(remainder_r) + fsta_pkg::SUM_W'(q_item.frame_time);
              dvd_r   <= fsta_pkg::SUM_W'(remainder_r) + fsta_pkg::SUM_W'(q_item.frame_time);
              part_r  <= '0;
              cnt_r   <= fsta_pkg::CNT_W'(fsta_pkg::SUM_W);
              sat_r   <= 1'b0;
              state_r <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          part_r <= part_nxt;
          dvd_r  <= dvd_r << 1;
          quo_r  <= {quo_r[fsta_pkg::SUM_W-2:0], trial_ge};
          cnt_r  <= cnt_r - 1'b1;
          if (cnt_r == fsta_pkg::CNT_W'(1)) begin
            state_r <= ST_POST;
          end
        end
        ST_POST: begin
          // quotient and remainder are final; part_r stays as blend dividend
          remainder_r <= part_r;
          steps_r     <= steps_nxt;
          tick_r      <= tick_r + fsta_pkg::TICK_W'(steps_nxt);
          if (over_cap) begin
            drop_r <= drop_nxt;
          end
          dvd_r   <= '0;
          cnt_r   <= fsta_pkg::CNT_W'(fsta_pkg::FRAC_BITS);
          state_r <= ST_FRAC;
        end
        ST_FRAC: begin
          part_r <= part_nxt;
          dvd_r  <= dvd_r << 1;
          quo_r  <= {quo_r[fsta_pkg::SUM_W-2:0], trial_ge};
          cnt_r  <= cnt_r - 1'b1;
          if (cnt_r == fsta_pkg::CNT_W'(1)) begin
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_steps_r <= steps_r;
            out_ticks_r <= tick_r;
            // saturated blend is the largest fraction below one
            out_blend_r <= sat_r
                         ? fsta_pkg::BLEND_W'((64'd1 << fsta_pkg::FRAC_BITS) - 64'd1)
                         : quo_r[fsta_pkg::BLEND_W-1:0];
            out_drop_r  <= drop_r;
            out_invc_r  <= invc_r;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_steps_run      = out_steps_r;
  assign out_total_ticks    = out_ticks_r;
  assign out_blend_fraction = out_blend_r;
  assign out_dropped_total  = out_drop_r;
  assign out_invalid_count  = out_invc_r;

endmodule
`default_nettype wire

// File: rtl/fixed_step_tick_accumulator.sv
// a valid frame passes the states DIV (33 quotient bits), POST, FRAC (16 fraction
//   bits) and FIN; an invalid frame skips DIV and POST, and one whose remainder is
//   not below the step length also skips FRAC; all division runs on the shared
//   one-bit-per-cycle restoring divider, which takes a new request only when idle
// a two-entry request queue takes new requests while the divider works, until full
// reset: synchronous active-low rst_n clears totals, remainder, queue and output
`default_nettype none
module fixed_step_tick_accumulator (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] in_frame_time,
  input  wire logic        in_frame_invalid,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_steps_run,
  output logic [47:0]      out_total_ticks,
  output logic [15:0]      out_blend_fraction,
  output logic [47:0]      out_dropped_total,
  output logic [31:0]      out_invalid_count,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [27:0] cfg_data
);

  fsta_pkg::fsta_cfg_t  cfg_r;
  fsta_pkg::fsta_item_t q_item;
  logic                 q_valid;
  logic                 q_pop;

  // configuration registers, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.step_length <= fsta_pkg::STEP_RESET;
      cfg_r.max_steps   <= fsta_pkg::CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        fsta_pkg::REG_STEP_LENGTH: cfg_r.step_length <= cfg_data;
        fsta_pkg::REG_MAX_STEPS:   cfg_r.max_steps   <= cfg_data[fsta_pkg::CAP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // request intake and queue
  fsta_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_frame_time    (in_frame_time),
    .in_frame_invalid (in_frame_invalid),
    .q_valid          (q_valid),
    .q_item           (q_item),
    .q_pop            (q_pop)
  );

  // division, totals and result register
  fsta_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg_r),
    .q_valid            (q_valid),
    .q_item             (q_item),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_steps_run      (out_steps_run),
    .out_total_ticks    (out_total_ticks),
    .out_blend_fraction (out_blend_fraction),
    .out_dropped_total  (out_dropped_total),
    .out_invalid_count  (out_invalid_count)
  );

endmodule
`default_nettype wire

// File: rtl/fsta_checker.sv
`default_nettype none
module fsta_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_stall,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [7:0]  out_steps_run,
  input  wire logic [47:0] out_total_ticks,
  input  wire logic [47:0] out_dropped_total
);

  logic        seen_r;
  logic [47:0] last_ticks_r;
  logic [47:0] last_drop_r;

  // remember totals of the last delivered result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= 1'b0;
    end else if (out_valid && !out_stall) begin
      seen_r       <= 1'b1;
      last_ticks_r <= out_total_ticks;
      last_drop_r  <= out_dropped_total;
    end
  end

  // reset empties the queue and the result register
  a_reset_clear: assert property (@(posedge clk) !rst_n |=> !out_valid && !in_stall)
    else $error("queue or result not empty after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_total_ticks)
      && $stable(out_steps_run))
    else $error("stalled result changed");

  // tick total advances by exactly the steps of each result
  a_tick_chain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && seen_r |->
      out_total_ticks == 48'(last_ticks_r + 48'(out_steps_run)))
    else $error("tick total does not follow steps run");

  // dropped time never goes down
  a_drop_mono: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && seen_r |-> out_dropped_total >= last_drop_r)
    else $error("dropped total decreased");

endmodule

bind fixed_step_tick_accumulator fsta_checker u_fsta_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_steps_run     (out_steps_run),
  .out_total_ticks   (out_total_ticks),
  .out_dropped_total (out_dropped_total)
);
`default_nettype wire
